// ===== rtl/core/lfid_pkg.sv =====
// Shared types and constants for the lowest-free-id sorted table unit.
// Request and response payload structs, opcode and status codes, controller states.
// No dependencies.
package lfid_pkg;

	localparam int DEFAULT_CAPACITY = 64;
	localparam int ID_W             = 7;
	localparam int POS_W            = 6;
	localparam int COUNT_W          = 7;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_ID_ZERO   = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  release_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]    given_id;
		logic [POS_W-1:0]   table_position;
		status_t            status;
		logic [COUNT_W-1:0] used_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_COMMIT
	} lfid_state_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic look;
		logic update;
		op_t  op;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/lfid_cell.sv =====
// One slot of the sorted id table: holds an id and its valid flag.
// Exchanges ids with its two neighbours on insert and remove. Depends on lfid_pkg.
module lfid_cell import lfid_pkg::*; #(
	parameter int IdW = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cell_ctrl_t     ctrl,
	input  logic [IdW-1:0] slot_id,
	input  logic [IdW-1:0] key,
	input  logic [IdW-1:0] prev_id,
	input  logic           prev_valid,
	input  logic           prev_in_prefix,
	input  logic [IdW-1:0] next_id,
	input  logic           next_valid,
	output logic [IdW-1:0] id,
	output logic           valid,
	output logic           in_prefix,
	output logic           hit
);

	logic [IdW-1:0] id_q;
	logic           valid_q;
	logic           hit_q;
	logic           alloc_here;
	logic           alloc_after;
	logic           rel_eq;
	logic           rel_shift;

	// Sorted distinct ids starting at 1 keep id >= slot, so the unbroken run is a prefix.
	assign in_prefix   = valid_q && (id_q == slot_id);
	assign alloc_here  = !in_prefix && prev_in_prefix;
	assign alloc_after = !prev_in_prefix;
	assign rel_eq      = valid_q && (id_q == key);
	assign rel_shift   = !valid_q || (id_q >= key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.look) begin
				hit_q <= (ctrl.op == OP_RELEASE) ? rel_eq : alloc_here;
			end
			if (ctrl.update) begin
				if (ctrl.op == OP_ALLOC) begin
					// Slots inside the unbroken run keep their contents.
					if (alloc_here) begin
						valid_q <= 1'b1;
					end else if (alloc_after) begin
						valid_q <= prev_valid;
					end
				end else if (rel_shift) begin
					valid_q <= next_valid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			if (ctrl.op == OP_ALLOC) begin
				if (alloc_here) begin
					id_q <= slot_id;
				end else if (alloc_after) begin
					id_q <= prev_id;
				end
			end else if (rel_shift) begin
				id_q <= next_id;
			end
		end
	end

	assign id    = id_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule

// ===== rtl/core/lowest_free_id_sorted_table_unit.sv =====
// Top level of the lowest-free-id allocator: a chain of lfid_cell slots and its sequencer.
// Depends on lfid_pkg and lfid_cell.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_t: op, release_id
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_t: given_id, table_position, status, used_count
//
// Every request passes in order from its transfer to its response: a look state in which
// all cells compare against the request at once and register a hit flag, a commit state in
// which the hit flags are encoded and the chain shifts by one slot, then the response.
// A new request is taken in the cycle after the commit, even while the response waits.
// Reset clears the valid flags, the entry count and the sequencer; ids need no reset.
// A stalled response holds the commit of the following request until it is taken.
module lowest_free_id_sorted_table_unit import lfid_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Ids run from 1 to CAPACITY; the count runs from 0 to CAPACITY.
	localparam int IdW  = $clog2(CAPACITY + 1);
	localparam int PosW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int KeyW = (IdW > ID_W) ? IdW : ID_W;

	lfid_state_t state_q;
	lfid_state_t state_d;

	op_t              op_q;
	logic [ID_W-1:0]  rid_q;
	logic [IdW-1:0]   count_q;
	logic [IdW-1:0]   count_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	cell_ctrl_t       ctrl;
	logic             commit_go;
	logic [KeyW-1:0]  key_wide;
	logic             rid_over;
	logic [IdW-1:0]   key;

	logic [IdW-1:0]      id_vec     [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] prefix_vec;
	logic [CAPACITY-1:0] hit_vec;

	logic             full;
	logic             found;
	logic [PosW-1:0]  pos;
	logic             ok;
	status_t          status;
	logic [IdW-1:0]   alloc_id;

	// The request id is compared in the wider of the two widths so that an id
	// above the capacity can never alias onto a stored one.
	assign key_wide = KeyW'(rid_q);
	assign rid_over = key_wide > KeyW'(CAPACITY);
	assign key      = key_wide[IdW-1:0];

	// The chain of slots. Slot 0 sees an unbroken run before it; the last slot sees
	// an empty neighbour beyond it.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [IdW-1:0] prev_id;
		logic           prev_valid;
		logic           prev_in_prefix;
		logic [IdW-1:0] next_id;
		logic           next_valid;

		if (i == 0) begin : g_first
			assign prev_id        = '0;
			assign prev_valid     = 1'b0;
			assign prev_in_prefix = 1'b1;
		end else begin : g_mid
			assign prev_id        = id_vec[i-1];
			assign prev_valid     = valid_vec[i-1];
			assign prev_in_prefix = prefix_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_id    = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_id    = id_vec[i+1];
			assign next_valid = valid_vec[i+1];
		end

		lfid_cell #(
			.IdW(IdW)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctrl           (ctrl),
			.slot_id        (IdW'(i + 1)),
			.key            (key),
			.prev_id        (prev_id),
			.prev_valid     (prev_valid),
			.prev_in_prefix (prev_in_prefix),
			.next_id        (next_id),
			.next_valid     (next_valid),
			.id             (id_vec[i]),
			.valid          (valid_vec[i]),
			.in_prefix      (prefix_vec[i]),
			.hit            (hit_vec[i])
		);
	end

	// The registered hit flags are one-hot at most; their position is the table position.
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_vec[i]) begin
				pos = pos | PosW'(i);
			end
		end
	end

	assign full      = count_q == IdW'(CAPACITY);
	assign found     = (|hit_vec) && !rid_over;
	assign commit_go = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_ready);
	assign alloc_id  = IdW'(pos) + IdW'(1);

	// Decide the outcome of the request held in the commit cycle.
	always_comb begin
		ok     = 1'b0;
		status = STATUS_OK;
		if (op_q == OP_ALLOC) begin
			if (full) begin
				status = STATUS_FULL;
			end else begin
				ok = 1'b1;
			end
		end else if (rid_q == '0) begin
			status = STATUS_ID_ZERO;
		end else if (!found) begin
			status = STATUS_NOT_FOUND;
		end else begin
			ok = 1'b1;
		end
	end

	always_comb begin
		count_d = count_q;
		if (ok) begin
			count_d = (op_q == OP_ALLOC) ? count_q + IdW'(1) : count_q - IdW'(1);
		end
	end

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (commit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		req_ready   = 1'b0;
		ctrl.look   = 1'b0;
		ctrl.update = 1'b0;
		ctrl.op     = op_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_LOOK: begin
				ctrl.look = 1'b1;
			end
			ST_COMMIT: begin
				ctrl.update = commit_go && ok;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_go) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q  <= req.op;
			rid_q <= req.release_id;
		end
		if (commit_go) begin
			rsp_q.status     <= status;
			rsp_q.used_count <= COUNT_W'(count_d);
			if (ok) begin
				rsp_q.given_id       <= (op_q == OP_ALLOC) ? ID_W'(alloc_id) : rid_q;
				rsp_q.table_position <= POS_W'(pos);
			end else begin
				rsp_q.given_id       <= '0;
				rsp_q.table_position <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The entry count never passes the capacity.
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IdW'(CAPACITY))
		else $error("entry count beyond capacity");

	// The valid slots and the entry count always agree.
	a_count_matches_valid : assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("valid slots disagree with entry count");

	// At most one slot can claim a request.
	a_single_hit : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> $onehot0(hit_vec))
		else $error("more than one slot hit");

	// A commit always leaves a response behind.
	a_commit_responds : assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> rsp_valid)
		else $error("commit without response");

endmodule
